@@ rtl/peak_level_centroid_two_bands_unit_assert.svh @@
// Assertion macros shared by the checker of the peak-level centroid unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PEAK_LEVEL_CENTROID_TWO_BANDS_UNIT_ASSERT_SVH
`define PEAK_LEVEL_CENTROID_TWO_BANDS_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define PLC2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PLC2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/plc2_pkg.sv @@
// Shared types, constants and helpers of the peak-level centroid unit.
// No dependencies.
package plc2_pkg;

  localparam int MAX_DIM = 4096;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CFG_W   = 13;
  localparam int EXT_W   = (CFG_W > DIM_W) ? CFG_W : DIM_W;

  localparam int PIX_W   = 32;
  localparam int LVL_W   = 5;
  localparam int CNT_W   = 25;
  localparam int SUM_W   = 37;
  localparam int OSUM_W  = 36;

  localparam logic [PIX_W-1:0] MARK_FLOOR = 32'hFF01_0000;
  localparam logic [PIX_W-1:0] HIGH_FLOOR = 32'hFF80_0000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // One decoded pixel with its position, held between the two stages.
  typedef struct packed {
    logic             mark;
    logic             high;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row_up;
    logic             frame_end;
  } s1_t;

  // Totals of one band as they leave the block.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [OSUM_W-1:0] sum_x;
    logic [OSUM_W-1:0] sum_y;
    logic [LVL_W-1:0]  level;
  } tot_t;

  // A zero dimension counts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (ve == '0) begin
      return DIM_W'(1);
    end else if (ve > EXT_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(ve);
  endfunction

endpackage

@@ rtl/plc2_front.sv @@
// Input stage of the peak-level centroid unit: geometry registers, raster
// position counters, pixel decode and the stage register. Uses plc2_pkg.
module plc2_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [plc2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plc2_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [plc2_pkg::PIX_W-1:0]     in_pixel,
  input  logic                           s1_go,
  output logic                           s1_valid,
  output plc2_pkg::s1_t                  s1_word
);
  import plc2_pkg::*;

  logic [CFG_W-1:0] width_r, height_r;
  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic             s1_valid_r;
  s1_t              s1_r, s1_nxt;
  logic [DIM_W-1:0] w, h;
  logic             accept, row_end, last_row;
  logic [LVL_W-1:0] lvl_a, lvl_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w        = clamp_dim(width_r);
  assign h        = clamp_dim(height_r);
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  // Counters left past a shrunken geometry still end the row or frame.
  assign row_end  = (DIM_W'(col_r) + DIM_W'(1)) >= w;
  assign last_row = (DIM_W'(row_r) + DIM_W'(1)) >= h;
  assign lvl_a    = in_pixel[7:3];
  assign lvl_b    = in_pixel[15:11];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (!row_end) begin
      col_nxt = col_r + POS_W'(1);
    end else begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + POS_W'(1);
    end

    s1_nxt.mark      = in_pixel >= MARK_FLOOR;
    s1_nxt.high      = in_pixel >= HIGH_FLOOR;
    s1_nxt.level     = (lvl_a > lvl_b) ? lvl_a : lvl_b;
    s1_nxt.col       = col_r;
    s1_nxt.row_up    = (DIM_W'(row_r) < h) ? POS_W'(h - DIM_W'(1) - DIM_W'(row_r)) : '0;
    s1_nxt.frame_end = row_end && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_r;

endmodule

@@ rtl/plc2_band.sv @@
// Peak level, count and position sums of one band.
// Uses plc2_pkg; instantiated once per band by the top level.
module plc2_band (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       hit,
  input  logic                       flush,
  input  logic [plc2_pkg::LVL_W-1:0] level,
  input  logic [plc2_pkg::POS_W-1:0] col,
  input  logic [plc2_pkg::POS_W-1:0] row_up,
  output plc2_pkg::tot_t             tot
);
  import plc2_pkg::*;

  logic [LVL_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0] tally_r, tally_nxt;
  logic [SUM_W-1:0] xsum_r, xsum_nxt, ysum_r, ysum_nxt;
  logic             raise, take;

  // A higher level restarts the band; the pixel then counts at the new peak.
  assign raise = hit && (level > peak_r);
  assign take  = hit && (level >= peak_r);

  always_comb begin
    peak_nxt  = raise ? level : peak_r;
    tally_nxt = raise ? '0 : tally_r;
    xsum_nxt  = raise ? '0 : xsum_r;
    ysum_nxt  = raise ? '0 : ysum_r;
    if (take) begin
      tally_nxt = tally_nxt + CNT_W'(1);
      xsum_nxt  = xsum_nxt + SUM_W'(col);
      ysum_nxt  = ysum_nxt + SUM_W'(row_up);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= LVL_W'(1);
      tally_r <= '0;
      xsum_r  <= '0;
      ysum_r  <= '0;
    end else if (en) begin
      if (flush) begin
        peak_r  <= LVL_W'(1);
        tally_r <= '0;
        xsum_r  <= '0;
        ysum_r  <= '0;
      end else begin
        peak_r  <= peak_nxt;
        tally_r <= tally_nxt;
        xsum_r  <= xsum_nxt;
        ysum_r  <= ysum_nxt;
      end
    end
  end

  assign tot.count = tally_nxt;
  assign tot.sum_x = xsum_nxt[OSUM_W-1:0];
  assign tot.sum_y = ysum_nxt[OSUM_W-1:0];
  assign tot.level = peak_nxt;

endmodule

@@ rtl/peak_level_centroid_two_bands_unit.sv @@
// Top level of the two-band peak-level centroid unit.
// Uses plc2_pkg, plc2_front and plc2_band.
//
// Takes one 32-bit pixel per clock in raster order and, after the last pixel
// of each frame, delivers one word with each band's peak level, the count of
// pixels at that level and the sums of their columns and bottom-up rows.
// Every pixel passes an input stage register and one accumulate stage, and a
// frame's word is registered once its last pixel leaves the input stage; a held
// result word stalls intake only when the next frame also ends before it is
// taken. Frame size comes from frame_width and frame_height (reset 640 by
// 480, zero read as one, capped at 4096) and should be written between frames.
module peak_level_centroid_two_bands_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [plc2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plc2_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [plc2_pkg::PIX_W-1:0]     in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [plc2_pkg::CNT_W-1:0]     out_low_count,
  output logic [plc2_pkg::OSUM_W-1:0]    out_low_sum_x,
  output logic [plc2_pkg::OSUM_W-1:0]    out_low_sum_y,
  output logic [plc2_pkg::LVL_W-1:0]     out_low_level,
  output logic [plc2_pkg::CNT_W-1:0]     out_high_count,
  output logic [plc2_pkg::OSUM_W-1:0]    out_high_sum_x,
  output logic [plc2_pkg::OSUM_W-1:0]    out_high_sum_y,
  output logic [plc2_pkg::LVL_W-1:0]     out_high_level
);
  import plc2_pkg::*;

  logic s1_valid, s1_go, emit, out_valid_r;
  s1_t  s1_word;
  tot_t low_tot, high_tot, low_r, high_r;

  // Only a frame-ending word has to wait for room in the result register.
  assign s1_go = s1_valid && !(s1_word.frame_end && out_valid_r && !out_ready);
  assign emit  = s1_go && s1_word.frame_end;

  plc2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .s1_go     (s1_go),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word)
  );

  plc2_band u_low (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (s1_go),
    .hit    (s1_word.mark && !s1_word.high),
    .flush  (s1_word.frame_end),
    .level  (s1_word.level),
    .col    (s1_word.col),
    .row_up (s1_word.row_up),
    .tot    (low_tot)
  );

  plc2_band u_high (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (s1_go),
    .hit    (s1_word.mark && s1_word.high),
    .flush  (s1_word.frame_end),
    .level  (s1_word.level),
    .col    (s1_word.col),
    .row_up (s1_word.row_up),
    .tot    (high_tot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      low_r  <= low_tot;
      high_r <= high_tot;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_low_count  = low_r.count;
  assign out_low_sum_x  = low_r.sum_x;
  assign out_low_sum_y  = low_r.sum_y;
  assign out_low_level  = low_r.level;
  assign out_high_count = high_r.count;
  assign out_high_sum_x = high_r.sum_x;
  assign out_high_sum_y = high_r.sum_y;
  assign out_high_level = high_r.level;

endmodule

@@ rtl/plc2_chk.sv @@
// Port-level checker of the peak-level centroid unit, bound to the top level.
// Uses plc2_pkg and the assertion macros header.
`include "peak_level_centroid_two_bands_unit_assert.svh"

module plc2_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [plc2_pkg::CNT_W-1:0]     out_low_count,
  input logic [plc2_pkg::OSUM_W-1:0]    out_low_sum_x,
  input logic [plc2_pkg::OSUM_W-1:0]    out_low_sum_y,
  input logic [plc2_pkg::LVL_W-1:0]     out_low_level,
  input logic [plc2_pkg::CNT_W-1:0]     out_high_count,
  input logic [plc2_pkg::OSUM_W-1:0]    out_high_sum_x,
  input logic [plc2_pkg::OSUM_W-1:0]    out_high_sum_y,
  input logic [plc2_pkg::LVL_W-1:0]     out_high_level
);
  import plc2_pkg::*;

  // A result word never leaves the output while it is held back.
  `PLC2_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")

  // No result word comes out of reset.
  `PLC2_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result word valid after reset")

  // A band's peak level starts at one and only ever rises.
  `PLC2_ASSERT(a_level_floor, out_valid |-> out_low_level != '0 && out_high_level != '0, "peak level of zero reported")

  // Sums can be nonzero only when some pixel was counted.
  `PLC2_ASSERT(a_low_empty, out_valid && out_low_count == '0 |-> out_low_sum_x == '0 && out_low_sum_y == '0, "low band sums without count")
  `PLC2_ASSERT(a_high_empty, out_valid && out_high_count == '0 |-> out_high_sum_x == '0 && out_high_sum_y == '0, "high band sums without count")

endmodule

bind peak_level_centroid_two_bands_unit plc2_chk u_plc2_chk (.*);

@@ test/peak_level_centroid_checker.sv @@
// Checker for the two-band peak-level centroid unit. It follows the config port
// and both word channels, predicts each frame's totals and compares them.
// Depends on plc2_pkg.
module peak_level_centroid_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [plc2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plc2_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [plc2_pkg::PIX_W-1:0]     in_pixel,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [plc2_pkg::CNT_W-1:0]     out_low_count,
  input  logic [plc2_pkg::OSUM_W-1:0]    out_low_sum_x,
  input  logic [plc2_pkg::OSUM_W-1:0]    out_low_sum_y,
  input  logic [plc2_pkg::LVL_W-1:0]     out_low_level,
  input  logic [plc2_pkg::CNT_W-1:0]     out_high_count,
  input  logic [plc2_pkg::OSUM_W-1:0]    out_high_sum_x,
  input  logic [plc2_pkg::OSUM_W-1:0]    out_high_sum_y,
  input  logic [plc2_pkg::LVL_W-1:0]     out_high_level,
  output int                             fail_count,
  output int                             pending_frames,
  output int                             frames_checked
);
  import plc2_pkg::*;

  typedef struct packed {
    logic [LVL_W-1:0] peak;
    logic [CNT_W-1:0] tally;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
  } band_acc_t;

  typedef struct packed {
    tot_t low;
    tot_t high;
  } frame_totals_t;

  localparam band_acc_t BAND_IDLE = '{peak: LVL_W'(1), tally: '0, col_sum: '0, row_sum: '0};

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  band_acc_t        low_acc;
  band_acc_t        high_acc;
  frame_totals_t    totals_q[$];
  int               errors = 0;
  int               checked = 0;

  function automatic logic [DIM_W-1:0] usable_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (v > CFG_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  // A higher level restarts the band; a level equal to the peak is counted.
  function automatic band_acc_t band_update(input band_acc_t acc, input logic [LVL_W-1:0] lvl,
                                            input logic [POS_W-1:0] col,
                                            input logic [POS_W-1:0] row_up);
    band_acc_t nxt;
    nxt = acc;
    if (lvl > nxt.peak) begin
      nxt = '{peak: lvl, tally: '0, col_sum: '0, row_sum: '0};
    end
    if (lvl == nxt.peak) begin
      nxt.tally   = nxt.tally + CNT_W'(1);
      nxt.col_sum = nxt.col_sum + SUM_W'(col);
      nxt.row_sum = nxt.row_sum + SUM_W'(row_up);
    end
    return nxt;
  endfunction

  function automatic tot_t band_totals(input band_acc_t acc);
    tot_t t;
    t.count = acc.tally;
    t.sum_x = acc.col_sum[OSUM_W-1:0];
    t.sum_y = acc.row_sum[OSUM_W-1:0];
    t.level = acc.peak;
    return t;
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] pix);
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [LVL_W-1:0] lvl;
    logic [POS_W-1:0] row_up;
    w = usable_dim(width_reg);
    h = usable_dim(height_reg);
    if (pix >= MARK_FLOOR) begin
      lvl = (pix[7:3] > pix[15:11]) ? pix[7:3] : pix[15:11];
      // A row counter left past the last row by a smaller height counts as row 0.
      row_up = (row_pos < h) ? POS_W'(h - 1 - row_pos) : '0;
      if (pix < HIGH_FLOOR) begin
        low_acc = band_update(low_acc, lvl, col_pos, row_up);
      end else begin
        high_acc = band_update(high_acc, lvl, col_pos, row_up);
      end
    end
    if (col_pos + 1 < w) begin
      col_pos = col_pos + POS_W'(1);
    end else begin
      col_pos = '0;
      if (row_pos + 1 < h) begin
        row_pos = row_pos + POS_W'(1);
      end else begin
        totals_q.push_back('{low: band_totals(low_acc), high: band_totals(high_acc)});
        row_pos  = '0;
        low_acc  = BAND_IDLE;
        high_acc = BAND_IDLE;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic compare_result();
    frame_totals_t want;
    if (totals_q.size() == 0) begin
      $error("result word arrived with no frame totals pending");
      errors++;
    end else begin
      want = totals_q.pop_front();
      check_field("low_count", want.low.count, out_low_count);
      check_field("low_sum_x", want.low.sum_x, out_low_sum_x);
      check_field("low_sum_y", want.low.sum_y, out_low_sum_y);
      check_field("low_level", want.low.level, out_low_level);
      check_field("high_count", want.high.count, out_high_count);
      check_field("high_sum_x", want.high.sum_x, out_high_sum_x);
      check_field("high_sum_y", want.high.sum_y, out_high_sum_y);
      check_field("high_level", want.high.level, out_high_level);
      checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pos    = '0;
      row_pos    = '0;
      low_acc    = BAND_IDLE;
      high_acc   = BAND_IDLE;
      totals_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        compare_result();
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_wdata;
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_wdata;
        end
      end
      if (in_valid && in_ready) begin
        take_pixel(in_pixel);
      end
    end
    // Published after the edge so the stimulus side never races these counts.
    fail_count     <= errors;
    pending_frames <= totals_q.size();
    frames_checked <= checked;
  end

endmodule

@@ test/tb_peak_level_centroid_two_bands_unit.sv @@
// Testbench top for the two-band peak-level centroid unit: clock, reset,
// pixel and config stimulus, result sink and the verdict.
// Depends on plc2_pkg, peak_level_centroid_checker and the unit itself.
module tb_peak_level_centroid_two_bands_unit;
  import plc2_pkg::*;

  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_CYCLES  = 300;
  localparam int RANDOM_WORDS  = 1150;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic [CNT_W-1:0]     out_low_count;
  logic [OSUM_W-1:0]    out_low_sum_x;
  logic [OSUM_W-1:0]    out_low_sum_y;
  logic [LVL_W-1:0]     out_low_level;
  logic [CNT_W-1:0]     out_high_count;
  logic [OSUM_W-1:0]    out_high_sum_x;
  logic [OSUM_W-1:0]    out_high_sum_y;
  logic [LVL_W-1:0]     out_high_level;

  int fail_count;
  int pending_frames;
  int frames_checked;
  int words_sent = 0;
  int geometries = 0;
  int tx_quiet = 0;
  int rx_quiet = 0;
  bit stall_req = 1'b0;
  bit stall_done = 1'b0;

  always #10 clk = ~clk;

  peak_level_centroid_two_bands_unit DUT (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_pixel, .out_valid, .out_ready,
    .out_low_count, .out_low_sum_x, .out_low_sum_y, .out_low_level,
    .out_high_count, .out_high_sum_x, .out_high_sum_y, .out_high_level
  );

  peak_level_centroid_checker u_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_pixel, .out_valid, .out_ready,
    .out_low_count, .out_low_sum_x, .out_low_sum_y, .out_low_level,
    .out_high_count, .out_high_sum_x, .out_high_sum_y, .out_high_level,
    .fail_count, .pending_frames, .frames_checked
  );

  // Mostly no gap, sometimes a short one, rarely a long one, and now and then
  // a quiet stretch with no gaps at all.
  function automatic int next_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      quiet_left = $urandom_range(40, 150);
      return 0;
    end
    if ($urandom_range(0, 3) != 0) begin
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(input int lvl_cap);
    logic [PIX_W-1:0] pix;
    int kind;
    pix  = $urandom();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      return pix;
    end
    if (kind == 1) begin
      // Just under the mark floor: never counted whatever the level fields say.
      pix[31:16] = 16'hFF00;
      return pix;
    end
    if (kind < 6) begin
      pix[31:16] = 16'hFF01 + 16'($urandom_range(0, 16'h7E));
    end else begin
      pix[31:16] = 16'hFF80 + 16'($urandom_range(0, 16'h7F));
    end
    pix[7:3]   = 5'($urandom_range(0, lvl_cap));
    pix[15:11] = 5'($urandom_range(0, lvl_cap));
    return pix;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 2))
      0:       return MAX_DIM;
      1:       return MAX_DIM + 1;
      default: return (1 << CFG_W) - 1;
    endcase
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input int idle);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Waits until every predicted frame result has been taken, then lets the
  // two-stage pipeline settle so a config write finds the unit idle.
  task automatic drain_results();
    int n;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (pending_frames != 0 && n < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    drain_results();
  endtask

  task automatic set_geometry(input int w, input int h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    geometries++;
  endtask

  task automatic run_phase(input int w, input int h, input int n, input int lvl_cap,
                           input bit paced);
    set_geometry(w, h);
    repeat (n) push_pixel(make_pixel(lvl_cap), paced ? next_gap(tx_quiet) : 0);
    end_burst();
  endtask

  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_req && !stall_done) begin
        // Long hold-off so finished frames pile up and the unit stops intake.
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end else begin
        gap = next_gap(rx_quiet);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int r;
    int w;
    int h;
    int wc;
    int hc;
    int n;
    int lvl_cap;
    int sent;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One 4x3 frame walking the band edges, level zero, ties and raises.
    set_geometry(4, 3);
    push_pixel(32'h0000_0000, next_gap(tx_quiet));
    push_pixel(32'hFF00_FFFF, next_gap(tx_quiet));
    push_pixel(32'hFF01_0000, next_gap(tx_quiet));
    push_pixel(32'hFF01_0008, next_gap(tx_quiet));
    push_pixel(32'hFF80_0000, next_gap(tx_quiet));
    push_pixel(32'hFF7F_FFFF, next_gap(tx_quiet));
    push_pixel(32'hFF7F_F8F8, next_gap(tx_quiet));
    push_pixel(32'hFF80_8800, next_gap(tx_quiet));
    push_pixel(32'hFF80_0088, next_gap(tx_quiet));
    push_pixel(32'hFFFF_0010, next_gap(tx_quiet));
    push_pixel(32'hFFFF_FFFF, next_gap(tx_quiet));
    push_pixel(32'hFFFF_F800, next_gap(tx_quiet));
    end_burst();

    // Zero geometry reads as 1x1: an empty frame, then a single counted pixel.
    set_geometry(0, 0);
    push_pixel(32'h1234_5678, next_gap(tx_quiet));
    push_pixel(32'hFF7F_0008, next_gap(tx_quiet));
    end_burst();

    // Tall column left mid-frame, then a smaller height ends it from past the last row.
    set_geometry(1, MAX_DIM);
    push_pixel(32'hFFFF_FFFF, next_gap(tx_quiet));
    push_pixel(32'hFF7F_FFFF, next_gap(tx_quiet));
    push_pixel(32'hFFC0_F8F8, next_gap(tx_quiet));
    end_burst();
    set_geometry(1, 2);
    push_pixel(32'hFFFF_FFFF, next_gap(tx_quiet));
    end_burst();

    // One wide two-row frame so the sums collect many terms at a low level cap.
    run_phase(256, 2, 512, 2, 1'b1);

    // One-pixel frames sent back to back while the sink holds off.
    stall_req = 1'b1;
    run_phase(1, 1, 60, 31, 1'b0);
    stall_req = 1'b0;

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      r       = $urandom_range(0, 19);
      lvl_cap = $urandom_range(0, 31);
      if (r == 0) begin
        w = pick_extreme();
        h = $urandom_range(1, 3);
        n = $urandom_range(1, 30);
      end else if (r == 1) begin
        w = $urandom_range(1, 3);
        h = pick_extreme();
        n = $urandom_range(1, 30);
      end else begin
        w  = $urandom_range(0, 8);
        h  = $urandom_range(0, 6);
        wc = (w == 0) ? 1 : w;
        hc = (h == 0) ? 1 : h;
        n  = $urandom_range(1, 4) * wc * hc;
        // Some phases stop inside a frame, so the next geometry lands mid-frame.
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, n + wc);
        end
      end
      run_phase(w, h, n, lvl_cap, 1'b1);
      sent += n;
    end

    drain_results();
    $display("Sent %0d pixel words over %0d frame geometries, including extremes and a long sink stall.",
             words_sent, geometries);
    $display("Compared %0d frame results.", frames_checked);
    if (fail_count == 0 && pending_frames == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
